/* design/game_handshake_filter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Handshake filter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAME_HANDSHAKE_FILTER_UNIT_MACROS_SVH
`define GAME_HANDSHAKE_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define GHF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ghf_pkg.sv */
// ----------------------------------------------------------------------------
// Handshake filter package
// Constants, phase and cause codes, and shared types.
// ----------------------------------------------------------------------------
package ghf_pkg;

  localparam int MAX_VARINT_BYTES = 5;
  localparam int MAX_ADDRESS_LEN  = 1024;
  localparam int PORT_BYTES       = 2;

  localparam int PHASE_W = 3;
  localparam int COUNT_W = 3;
  localparam int SKIP_W  = 11;
  localparam int CFG_IDX_W = 2;

  // parse phases
  localparam logic [PHASE_W-1:0] PH_LEN     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ID      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PROTO   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ADDRLEN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ADDR    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PORT    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_NEXT    = 3'd6;

  // reject causes
  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_PROTO     = 2'd1;
  localparam logic [1:0] CAUSE_NEXT      = 2'd2;
  localparam logic [1:0] CAUSE_MALFORMED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_STATE_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_STATE_MAX = 2'd3;

  localparam logic [31:0] PROTOCOL_MIN_RST   = 32'd250;
  localparam logic [31:0] PROTOCOL_MAX_RST   = 32'd340;
  localparam logic [7:0]  NEXT_STATE_MIN_RST = 8'd1;
  localparam logic [7:0]  NEXT_STATE_MAX_RST = 8'd2;

  typedef struct packed {
    logic [31:0] protocol_min;
    logic [31:0] protocol_max;
    logic [7:0]  next_state_min;
    logic [7:0]  next_state_max;
  } ghf_cfg_t;

  typedef struct packed {
    logic [31:0] next_state_seen;
    logic [31:0] protocol_seen;
    logic [1:0]  reject_cause;
    logic        verdict;
  } ghf_result_t;

endpackage

/* design/ghf_cfg.sv */
// ----------------------------------------------------------------------------
// Handshake filter configuration registers
// Holds the protocol and next-state acceptance ranges.
// ----------------------------------------------------------------------------
module ghf_cfg
  import ghf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output ghf_cfg_t             cfg_o
);

  ghf_cfg_t cfg_r;
  ghf_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROTOCOL_MIN:   cfg_nxt.protocol_min   = cfg_data;
        REG_PROTOCOL_MAX:   cfg_nxt.protocol_max   = cfg_data;
        REG_NEXT_STATE_MIN: cfg_nxt.next_state_min = cfg_data[7:0];
        REG_NEXT_STATE_MAX: cfg_nxt.next_state_max = cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_min   <= PROTOCOL_MIN_RST;
      cfg_r.protocol_max   <= PROTOCOL_MAX_RST;
      cfg_r.next_state_min <= NEXT_STATE_MIN_RST;
      cfg_r.next_state_max <= NEXT_STATE_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/ghf_parser.sv */
// ----------------------------------------------------------------------------
// Handshake filter byte parser
// Per-byte handshake parse state and verdict logic.
// ----------------------------------------------------------------------------
module ghf_parser
  import ghf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        conn_start,
  input  ghf_cfg_t    cfg_i,
  output logic        emit,
  output ghf_result_t result
);

  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_eff;
  logic [31:0]        accum_r, accum_nxt, accum_eff;
  logic [COUNT_W-1:0] count_r, count_nxt, count_eff;
  logic [SKIP_W-1:0]  skip_r, skip_nxt, skip_eff, skip_dec;
  logic [31:0]        hold_r, hold_nxt, hold_eff;
  logic               judged_r, judged_nxt, judged_eff;
  logic [31:0]        shifted;
  logic [31:0]        value;
  logic               too_long;

  // a new connection clears the parser before this byte is parsed
  always_comb begin
    if (conn_start) begin
      phase_eff  = PH_LEN;
      accum_eff  = '0;
      count_eff  = '0;
      skip_eff   = '0;
      hold_eff   = '0;
      judged_eff = 1'b0;
    end else begin
      phase_eff  = phase_r;
      accum_eff  = accum_r;
      count_eff  = count_r;
      skip_eff   = skip_r;
      hold_eff   = hold_r;
      judged_eff = judged_r;
    end
  end

  always_comb begin
    case (count_eff)
      3'd0:    shifted = 32'(data_byte[6:0]);
      3'd1:    shifted = 32'(data_byte[6:0]) << 7;
      3'd2:    shifted = 32'(data_byte[6:0]) << 14;
      3'd3:    shifted = 32'(data_byte[6:0]) << 21;
      3'd4:    shifted = 32'(data_byte[6:0]) << 28;
      default: shifted = '0;
    endcase
  end

  assign value    = accum_eff | shifted;
  assign too_long = (count_eff >= COUNT_W'(MAX_VARINT_BYTES)) || (count_eff > 3'd4);
  assign skip_dec = (skip_eff != '0) ? skip_eff - 1'b1 : skip_eff;

  always_comb begin
    phase_nxt  = phase_eff;
    accum_nxt  = accum_eff;
    count_nxt  = count_eff;
    skip_nxt   = skip_eff;
    hold_nxt   = hold_eff;
    judged_nxt = judged_eff;
    emit       = 1'b0;
    result     = '0;
    if (!judged_eff) begin
      unique case (phase_eff) inside
        PH_LEN, PH_PROTO, PH_ADDRLEN, PH_NEXT: begin
          if (too_long) begin
            emit                 = 1'b1;
            judged_nxt           = 1'b1;
            result.verdict       = 1'b1;
            result.reject_cause  = CAUSE_MALFORMED;
            result.protocol_seen = hold_eff;
          end else if (data_byte[7]) begin
            accum_nxt = value;
            count_nxt = count_eff + 1'b1;
          end else begin
            accum_nxt = '0;
            count_nxt = '0;
            if (phase_eff == PH_LEN) begin
              phase_nxt = PH_ID;
            end else if (phase_eff == PH_PROTO) begin
              hold_nxt  = value;
              phase_nxt = PH_ADDRLEN;
            end else if (phase_eff == PH_ADDRLEN) begin
              if (value > 32'(MAX_ADDRESS_LEN)) begin
                emit                 = 1'b1;
                judged_nxt           = 1'b1;
                result.verdict       = 1'b1;
                result.reject_cause  = CAUSE_MALFORMED;
                result.protocol_seen = hold_eff;
              end else if (value == '0) begin
                skip_nxt  = SKIP_W'(PORT_BYTES);
                phase_nxt = PH_PORT;
              end else begin
                skip_nxt  = value[SKIP_W-1:0];
                phase_nxt = PH_ADDR;
              end
            end else begin
              emit                   = 1'b1;
              judged_nxt             = 1'b1;
              result.protocol_seen   = hold_eff;
              result.next_state_seen = value;
              if (hold_eff < cfg_i.protocol_min || hold_eff > cfg_i.protocol_max) begin
                result.verdict      = 1'b1;
                result.reject_cause = CAUSE_PROTO;
              end else if (value < 32'(cfg_i.next_state_min) ||
                           value > 32'(cfg_i.next_state_max)) begin
                result.verdict      = 1'b1;
                result.reject_cause = CAUSE_NEXT;
              end else begin
                result.verdict      = 1'b0;
                result.reject_cause = CAUSE_NONE;
              end
            end
          end
        end
        PH_ID: phase_nxt = PH_PROTO;
        PH_ADDR: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            skip_nxt  = SKIP_W'(PORT_BYTES);
            phase_nxt = PH_PORT;
          end
        end
        PH_PORT: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_NEXT;
          end
        end
        default: phase_nxt = PH_LEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      accum_r  <= '0;
      count_r  <= '0;
      skip_r   <= '0;
      hold_r   <= '0;
      judged_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      count_r  <= count_nxt;
      skip_r   <= skip_nxt;
      hold_r   <= hold_nxt;
      judged_r <= judged_nxt;
    end
  end

endmodule

/* design/game_handshake_filter_unit.sv */
// ----------------------------------------------------------------------------
// Game handshake filter
// Parses the opening handshake of a client connection and gives one verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one client-to-server byte per transaction; in_tuser marks the
//           first byte of a new connection and restarts the parser.
//   out_* : one transaction per finished handshake (verdict, cause, decoded
//           protocol and next state); bytes that finish nothing give none.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Path: a byte is registered at the input, parsed as it leaves the input
//   register, and its verdict is registered in the result register on out_*.
// Throughput: one byte per cycle while out_* is not stalled; the parser state
//   update is combinational logic between the input register and the result register.
// Reset: parser in the length phase, ranges at 250..340 and 1..2, no result.
// Stall: a result waiting on out_tready holds the input register; the input
//   register still accepts one more byte, then in_tready drops.
// ----------------------------------------------------------------------------
`include "game_handshake_filter_unit_macros.svh"

module game_handshake_filter_unit
  import ghf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // input bytes
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] conn_start
  // verdicts
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [31:0] protocol_seen, [63:32] next_state_seen
  output logic [2:0]           out_tuser   // [0] verdict, [2:1] reject_cause
);

  ghf_cfg_t    cfg;
  ghf_result_t res;
  ghf_result_t res_r;
  logic        emit;
  logic [7:0]  byte_r;
  logic        start_r;
  logic        in_valid_r, in_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        advance;

  ghf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // byte leaves the input register when the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ghf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (byte_r),
    .conn_start (start_r),
    .cfg_i      (cfg),
    .emit       (emit),
    .result     (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
    if (advance && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.next_state_seen, res_r.protocol_seen};
  assign out_tuser  = {res_r.reject_cause, res_r.verdict};

  `GHF_ASSERT_IMP(a_verdict_cause, out_tvalid,
    out_tuser[0] == (out_tuser[2:1] != CAUSE_NONE), "verdict and cause disagree")
  `GHF_ASSERT_IMP(a_malformed_no_next, out_tvalid && out_tuser[2:1] == CAUSE_MALFORMED,
    out_tdata[63:32] == 32'd0, "malformed result carries a next state")
  `GHF_ASSERT_IMP(a_full_blocks_input, in_valid_r && out_valid_r && !out_tready,
    !in_tready, "input taken while pipeline is blocked")
  `GHF_ASSERT_NXT(a_result_loaded, advance && emit, out_valid_r,
    "verdict lost on its way to the result register")

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Handshake filter testbench
// Feeds client byte streams into the filter through its input stream, with
// random gaps and output stalls, and checks every verdict transaction against
// an in-bench parser of the opening handshake. Runs several range settings,
// the widest, empty and single-value ranges among them.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ghf_pkg::*;

  localparam int IDLE_LIMIT      = 1000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int BYTES_PER_PHASE = 350;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } conn_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PROTOCOL_MIN;
  logic [31:0]          cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;
  logic [2:0]           out_tuser;

  game_handshake_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Handshake parser: ranges and per-connection state
  // --------------------------------------------------------------------------
  ghf_cfg_t            range_cfg = '{PROTOCOL_MIN_RST, PROTOCOL_MAX_RST,
                                     NEXT_STATE_MIN_RST, NEXT_STATE_MAX_RST};
  logic [PHASE_W-1:0]  hs_phase = PH_LEN;
  logic [31:0]         vi_accum = '0;
  logic [COUNT_W-1:0]  vi_count = '0;
  logic [SKIP_W-1:0]   skip_left = '0;
  logic [31:0]         proto_held = '0;
  logic                verdict_given = 1'b0;

  ghf_result_t verdict_q[$];
  conn_byte_t  byte_q[$];
  logic [7:0]  conn_buf[$];
  int          queued_bytes = 0;
  int          mismatch_cnt = 0;

  function automatic ghf_result_t issue_verdict(input logic rej, input logic [1:0] cause,
                                                input logic [31:0] next_val);
    ghf_result_t r;
    r.verdict         = rej;
    r.reject_cause    = cause;
    r.protocol_seen   = proto_held;
    r.next_state_seen = next_val;
    verdict_given     = 1'b1;
    return r;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a verdict.
  function automatic bit judge_byte(input logic [7:0] b, input logic first,
                                    output ghf_result_t res);
    logic [31:0] v;
    res = '0;
    if (first) begin
      hs_phase      = PH_LEN;
      vi_accum      = '0;
      vi_count      = '0;
      skip_left     = '0;
      proto_held    = '0;
      verdict_given = 1'b0;
    end
    if (verdict_given) return 1'b0;
    case (hs_phase)
      PH_LEN, PH_PROTO, PH_ADDRLEN, PH_NEXT: begin
        if (vi_count >= MAX_VARINT_BYTES) begin
          res = issue_verdict(1'b1, CAUSE_MALFORMED, '0);
          return 1'b1;
        end
        // bits shifted past 31 fall off
        vi_accum = vi_accum | (32'(b[6:0]) << (7 * vi_count));
        vi_count = vi_count + 1'b1;
        if (b[7]) return 1'b0;
        v        = vi_accum;
        vi_accum = '0;
        vi_count = '0;
        case (hs_phase)
          PH_LEN: hs_phase = PH_ID;
          PH_PROTO: begin
            proto_held = v;
            hs_phase   = PH_ADDRLEN;
          end
          PH_ADDRLEN: begin
            if (v > MAX_ADDRESS_LEN) begin
              res = issue_verdict(1'b1, CAUSE_MALFORMED, '0);
              return 1'b1;
            end
            if (v == 0) begin
              skip_left = SKIP_W'(PORT_BYTES);
              hs_phase  = PH_PORT;
            end else begin
              skip_left = v[SKIP_W-1:0];
              hs_phase  = PH_ADDR;
            end
          end
          default: begin
            if (proto_held < range_cfg.protocol_min || proto_held > range_cfg.protocol_max)
              res = issue_verdict(1'b1, CAUSE_PROTO, v);
            else if (v < {24'd0, range_cfg.next_state_min} ||
                     v > {24'd0, range_cfg.next_state_max})
              res = issue_verdict(1'b1, CAUSE_NEXT, v);
            else
              res = issue_verdict(1'b0, CAUSE_NONE, v);
            return 1'b1;
          end
        endcase
      end
      PH_ID: hs_phase = PH_PROTO;
      PH_ADDR: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin
          skip_left = SKIP_W'(PORT_BYTES);
          hs_phase  = PH_PORT;
        end
      end
      PH_PORT: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) hs_phase = PH_NEXT;
      end
      default: hs_phase = PH_LEN;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver
  // --------------------------------------------------------------------------
  int send_gap = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin : drive_bytes
    conn_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tuser  <= nxt.first;
        send_gap  <= send_burst ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 49) == 0) send_burst <= ~send_burst;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Verdict receiver: stall counted only while a verdict is offered
  // --------------------------------------------------------------------------
  int recv_stall = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin : accept_verdicts
    int s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      s = recv_burst ? 0 : $urandom_range(0, 5);
      recv_stall <= s;
      out_tready <= (s == 0);
      if ($urandom_range(0, 9) == 0) recv_burst <= ~recv_burst;
    end else if (recv_stall != 0) begin
      if (out_tvalid) begin
        recv_stall <= recv_stall - 1;
        out_tready <= (recv_stall == 1);
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : score
    ghf_result_t fresh, want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (judge_byte(in_tdata, in_tuser, fresh)) verdict_q.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        got.verdict         = out_tuser[0];
        got.reject_cause    = out_tuser[2:1];
        got.protocol_seen   = out_tdata[31:0];
        got.next_state_seen = out_tdata[63:32];
        if (verdict_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected verdict v=%0d cause=%0d proto=%0d next=%0d", $time,
                     got.verdict, got.reject_cause, got.protocol_seen, got.next_state_seen);
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict || got.reject_cause !== want.reject_cause ||
              got.protocol_seen !== want.protocol_seen ||
              got.next_state_seen !== want.next_state_seen) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch exp v=%0d c=%0d p=%0d n=%0d got v=%0d c=%0d p=%0d n=%0d",
                       $time, want.verdict, want.reject_cause, want.protocol_seen,
                       want.next_state_seen, got.verdict, got.reject_cause,
                       got.protocol_seen, got.next_state_seen);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stream builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data, input logic first);
    byte_q.push_back('{data: data, first: first});
    queued_bytes++;
  endtask

  // Base-128 encoding; sometimes padded with empty continuation bytes, and
  // stretched past the byte limit when overlong is set.
  task automatic add_varint(input logic [31:0] v, input bit overlong);
    int          n;
    int          total;
    logic [63:0] wide;
    logic [6:0]  d;
    n    = 1;
    wide = {32'd0, v};
    while (n < 5 && (wide >> (7 * n)) != 0) n++;
    if (overlong)
      total = $urandom_range(MAX_VARINT_BYTES + 1, MAX_VARINT_BYTES + 3);
    else if ($urandom_range(0, 7) == 0)
      total = $urandom_range(n, MAX_VARINT_BYTES);
    else
      total = n;
    for (int i = 0; i < total; i++) begin
      if (i < 5) d = wide[7*i +: 7];
      else d = 7'($urandom);
      // top bits of the fifth byte land above bit 31 and get dropped
      if (i == 4) d[6:4] = 3'($urandom);
      conn_buf.push_back({(i < total - 1), d});
    end
  endtask

  task automatic add_handshake(input logic [31:0] proto, input logic [31:0] addr_len,
                               input logic [31:0] next_val, input int bad_field);
    add_varint($urandom_range(0, 300), bad_field == 0);
    if (bad_field == 0) return;
    conn_buf.push_back(8'($urandom));
    add_varint(proto, bad_field == 1);
    if (bad_field == 1) return;
    add_varint(addr_len, bad_field == 2);
    if (bad_field == 2 || addr_len > MAX_ADDRESS_LEN) return;
    repeat (addr_len + PORT_BYTES) conn_buf.push_back(8'($urandom));
    add_varint(next_val, bad_field == 3);
  endtask

  function automatic logic [31:0] pick_near(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      4, 5, 6: begin
        if (lo > hi) return $urandom;
        return lo + 32'(64'($urandom) % (64'(hi) - 64'(lo) + 64'd1));
      end
      7: return $urandom;
      8: return $urandom_range(0, 127);
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_addr_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 75) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 40);
    if (r < 95) return MAX_ADDRESS_LEN + 1;
    return $urandom;
  endfunction

  // One connection: mostly complete handshakes, some cut short, some with an
  // overlong field, the rest raw noise.
  task automatic queue_conn();
    int   kind;
    int   keep;
    logic start_flag;
    conn_buf.delete();
    kind       = $urandom_range(0, 99);
    start_flag = ($urandom_range(0, 19) != 0);
    if (kind < 90) begin
      add_handshake(pick_near(range_cfg.protocol_min, range_cfg.protocol_max),
                    pick_addr_len(),
                    pick_near({24'd0, range_cfg.next_state_min},
                              {24'd0, range_cfg.next_state_max}),
                    (kind >= 80) ? $urandom_range(0, 3) : -1);
      if (kind >= 70 && kind < 80 && conn_buf.size() > 1) begin
        keep = $urandom_range(1, conn_buf.size() - 1);
        while (conn_buf.size() > keep) void'(conn_buf.pop_back());
      end
      repeat ($urandom_range(0, 3)) conn_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) conn_buf.push_back(8'($urandom));
    end
    foreach (conn_buf[i])
      push_byte(conn_buf[i], (i == 0) ? start_flag : ((kind >= 90) ? 1'($urandom) : 1'b0));
  endtask

  task automatic settle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_PROTOCOL_MIN:   range_cfg.protocol_min   = data;
      REG_PROTOCOL_MAX:   range_cfg.protocol_max   = data;
      REG_NEXT_STATE_MIN: range_cfg.next_state_min = data[7:0];
      default:            range_cfg.next_state_max = data[7:0];
    endcase
  endtask

  task automatic set_ranges(input logic [31:0] p_lo, input logic [31:0] p_hi,
                            input logic [7:0] ns_lo, input logic [7:0] ns_hi);
    put_reg(REG_PROTOCOL_MIN, p_lo);
    put_reg(REG_PROTOCOL_MAX, p_hi);
    put_reg(REG_NEXT_STATE_MIN, {24'd0, ns_lo});
    put_reg(REG_NEXT_STATE_MAX, {24'd0, ns_hi});
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_to(input int target);
    while (queued_bytes < target) queue_conn();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] p_lo;
    logic [7:0]  ns_lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // accepted handshake at the reset ranges, empty address, then a byte
    // that must be ignored after the verdict
    push_byte(8'h07, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'hFA, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h63, 1'b0);
    push_byte(8'hDD, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b0);
    // length varint runs past the byte limit
    push_byte(8'hFF, 1'b1);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    // protocol 340, address length one above the limit
    push_byte(8'h10, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'hD4, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'h81, 1'b0); push_byte(8'h08, 1'b0);
    // protocol and next state both out of range: protocol cause wins
    push_byte(8'h07, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    fill_to(BYTES_PER_PHASE);
    settle();

    // widest ranges, plus one address of the largest allowed length
    set_ranges(32'h0000_0000, 32'hFFFF_FFFF, 8'd0, 8'd255);
    conn_buf.delete();
    add_handshake(32'd300, MAX_ADDRESS_LEN, 32'd7, -1);
    foreach (conn_buf[i]) push_byte(conn_buf[i], i == 0);
    fill_to(2 * BYTES_PER_PHASE);
    settle();

    // min above max: everything is rejected
    set_ranges(32'd1000, 32'd999, 8'd200, 8'd100);
    fill_to(3 * BYTES_PER_PHASE);
    settle();

    p_lo  = $urandom_range(0, 500);
    ns_lo = 8'($urandom_range(0, 6));
    set_ranges(p_lo, p_lo + $urandom_range(0, 200), ns_lo,
               8'(ns_lo + $urandom_range(0, 3)));
    fill_to(4 * BYTES_PER_PHASE);
    settle();

    // single-value ranges at the top
    set_ranges(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255);
    fill_to(5 * BYTES_PER_PHASE);
    settle();

    if (mismatch_cnt == 0 && verdict_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ghf_pkg.sv
design/ghf_cfg.sv
design/ghf_parser.sv
design/game_handshake_filter_unit.sv
dv/tb_top.sv
